// File: rtl/btbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// btbs_pkg: shared types and constants of the bitrate selector
// Field widths, stream packing offsets, register map and the decision flags.
// -----------------------------------------------------------------------------
package btbs_pkg;

	localparam int RATE_W  = 32;
	localparam int BUF_W   = 32;
	localparam int QUAL_W  = 4;
	localparam int DELAY_W = 33;
	localparam int LCNT_W  = 5;

	// Input tdata packing, lowest bit first.
	localparam int IN_LIDX_LSB  = 0;
	localparam int IN_LRATE_LSB = IN_LIDX_LSB + QUAL_W;
	localparam int IN_CUR_LSB   = IN_LRATE_LSB + RATE_W;
	localparam int IN_EST_LSB   = IN_CUR_LSB + QUAL_W;
	localparam int IN_BUF_LSB   = IN_EST_LSB + RATE_W;
	localparam int IN_RISE_BIT  = IN_BUF_LSB + BUF_W;
	localparam int IN_FIRST_BIT = IN_RISE_BIT + 1;
	localparam int IN_TDATA_W   = 112;

	// Output tdata packing, lowest bit first.
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - QUAL_W - DELAY_W;

	// Configuration port.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BUFFER_MIN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BUFFER_LOW  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BUFFER_HIGH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SEGMENT_DUR = 3'd4;

	localparam logic [LCNT_W-1:0] RST_LEVEL_COUNT = 5'd16;
	localparam logic [BUF_W-1:0]  RST_BUFFER_MIN  = 32'd10000000;
	localparam logic [BUF_W-1:0]  RST_BUFFER_LOW  = 32'd20000000;
	localparam logic [BUF_W-1:0]  RST_BUFFER_HIGH = 32'd40000000;
	localparam logic [BUF_W-1:0]  RST_SEGMENT_DUR = 32'd2000000;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_DECIDE = 1'b1
	} op_t;

	// Outcome of every compare that the decision needs.
	typedef struct packed {
		logic fast_ok;     // 4*cur_rate <= 3*est
		logic up33_ok;     // 100*up_rate <= 33*est
		logic up50_ok;     // 2*up_rate <= est
		logic up75_ok;     // 4*up_rate <= 3*est
		logic up_hold;     // 10*up_rate >= 9*est
		logic cur_ge_est;  // cur_rate >= est
		logic lt_min;
		logic lt_low;
		logic lt_high;
		logic gt_high;
		logic is_top;
		logic rising;
	} dec_flags_t;

endpackage
`default_nettype wire

// File: rtl/btbs_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// btbs_decide: level and delay selection
// Turns the registered compare flags into the next level, the download delay
// and the end of the fast-start phase.
// -----------------------------------------------------------------------------
module btbs_decide import btbs_pkg::*; (
	input  wire logic               fast_start,
	input  wire dec_flags_t         flags,
	input  wire logic [QUAL_W-1:0]  cur,
	input  wire logic [QUAL_W-1:0]  up,
	input  wire logic [QUAL_W-1:0]  down,
	input  wire logic [DELAY_W-1:0] wait_us,
	input  wire logic [DELAY_W-1:0] fast_delay,
	output logic [QUAL_W-1:0]       next_level,
	output logic [DELAY_W-1:0]      delay_us,
	output logic                    fast_end
);

	logic fast_path;
	logic hold;

	assign fast_path = fast_start && !flags.is_top && flags.rising && flags.fast_ok;
	assign hold      = flags.is_top || flags.up_hold;
	assign fast_end  = !fast_path;

	always_comb begin
		next_level = cur;
		delay_us   = '0;
		if (fast_path) begin
			if (flags.lt_min) begin
				if (flags.up33_ok) next_level = up;
			end else if (flags.lt_low) begin
				if (flags.up50_ok) next_level = up;
			end else begin
				if (flags.up75_ok) next_level = up;
				if (flags.gt_high) delay_us = fast_delay;
			end
		end else begin
			if (flags.lt_min) begin
				next_level = '0;
			end else if (flags.lt_low) begin
				if (cur != '0 && flags.cur_ge_est) next_level = down;
			end else if (flags.lt_high) begin
				if (hold) delay_us = wait_us;
			end else begin
				if (hold) delay_us = wait_us;
				else next_level = up;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/buffer_threshold_bitrate_select_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// buffer_threshold_bitrate_select_top: buffer-based bitrate level chooser
// Rate table, configuration registers and a three-stage decision pipeline.
// -----------------------------------------------------------------------------
// Usage:
// The slave stream carries two kinds of transaction, chosen by s_tuser. A
// write transaction stores one level's bitrate in the rate table and yields
// no result. A decide transaction yields one result on the master stream
// (next level and download delay) unless its first-segment flag is set.
// The rate table read and the buffer compares are registered into stage 1
// at the accepting edge, the scaled rate compares into stage 2, then the
// decision goes into the output register, which drives m_tvalid.
// One transaction is accepted every cycle while s_tready is high; the three
// stages each hold one item and close bubbles when the receiver stalls, so
// s_tready drops only when all of them are full and m_tready is low.
// The user writes the configuration port only while no decision is in flight;
// the block does not enforce this. Reset loads the default thresholds, a level
// count of 16, turns fast start on and empties the pipeline. The rate table
// is not cleared; every entry must be written before a decision can reach it.
// -----------------------------------------------------------------------------
module buffer_threshold_bitrate_select_top import btbs_pkg::*; #(
	parameter int MAX_LEVELS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Slave stream.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// tdata: level_index, level_rate, prev_level, tput_est,
	//        buffer_level_us, buffer_rising, first_segment, zero pad
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	// tuser: op
	input  wire logic                  s_tuser,
	// Master stream.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// tdata: next_level, delay_us, zero pad
	output logic [OUT_TDATA_W-1:0]     m_tdata,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int TABLE_DEPTH = (MAX_LEVELS < 16) ? MAX_LEVELS : 16;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam logic [LCNT_W-1:0] COUNT_MAX = LCNT_W'(TABLE_DEPTH);

	// Configuration registers.
	logic [LCNT_W-1:0] level_count_q;
	logic [BUF_W-1:0]  buffer_min_q;
	logic [BUF_W-1:0]  buffer_low_q;
	logic [BUF_W-1:0]  buffer_high_q;
	logic [BUF_W-1:0]  segment_dur_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= RST_LEVEL_COUNT;
			buffer_min_q  <= RST_BUFFER_MIN;
			buffer_low_q  <= RST_BUFFER_LOW;
			buffer_high_q <= RST_BUFFER_HIGH;
			segment_dur_q <= RST_SEGMENT_DUR;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LEVEL_COUNT: level_count_q <= pwdata[LCNT_W-1:0];
				REG_BUFFER_MIN:  buffer_min_q  <= pwdata;
				REG_BUFFER_LOW:  buffer_low_q  <= pwdata;
				REG_BUFFER_HIGH: buffer_high_q <= pwdata;
				REG_SEGMENT_DUR: segment_dur_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LEVEL_COUNT: prdata = APB_DATA_W'(level_count_q);
			REG_BUFFER_MIN:  prdata = buffer_min_q;
			REG_BUFFER_LOW:  prdata = buffer_low_q;
			REG_BUFFER_HIGH: prdata = buffer_high_q;
			REG_SEGMENT_DUR: prdata = segment_dur_q;
			default:         prdata = '0;
		endcase
	end

	// Input fields.
	logic [QUAL_W-1:0] in_level_index;
	logic [RATE_W-1:0] in_level_rate;
	logic [QUAL_W-1:0] in_cur;
	logic [RATE_W-1:0] in_est;
	logic [BUF_W-1:0]  in_buf;
	logic              in_rising;
	logic              in_first;

	assign in_level_index = s_tdata[IN_LIDX_LSB +: QUAL_W];
	assign in_level_rate  = s_tdata[IN_LRATE_LSB +: RATE_W];
	assign in_cur         = s_tdata[IN_CUR_LSB +: QUAL_W];
	assign in_est         = s_tdata[IN_EST_LSB +: RATE_W];
	assign in_buf         = s_tdata[IN_BUF_LSB +: BUF_W];
	assign in_rising      = s_tdata[IN_RISE_BIT];
	assign in_first       = s_tdata[IN_FIRST_BIT];

	// Pipeline control.
	logic v_s1, v_s2, out_valid_q;
	logic en_s1, en_s2, en_s3;
	logic s_acc, wr_en, dec_acc;

	assign en_s3    = !out_valid_q || m_tready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign s_acc    = s_tvalid && s_tready;
	assign wr_en    = s_acc && (s_tuser == OP_WRITE)
		&& ({1'b0, in_level_index} < COUNT_MAX);
	assign dec_acc  = s_acc && (s_tuser == OP_DECIDE) && !in_first;

	// Level clamping and neighbors.
	logic [LCNT_W-1:0] count;
	logic [QUAL_W-1:0] top, cur_c, up_c, down_c;
	logic              is_top;

	always_comb begin
		if (level_count_q == '0) count = LCNT_W'(1);
		else if (level_count_q > COUNT_MAX) count = COUNT_MAX;
		else count = level_count_q;
		top    = QUAL_W'(count - LCNT_W'(1));
		cur_c  = (in_cur > top) ? top : in_cur;
		is_top = (cur_c == top);
		up_c   = is_top ? cur_c : cur_c + QUAL_W'(1);
		down_c = (cur_c == '0) ? cur_c : cur_c - QUAL_W'(1);
	end

	// Buffer zone compares and the hold-time candidate.
	logic [BUF_W-1:0]   bopt;
	logic [DELAY_W-1:0] bt_minus_taf, wait_c, fast_delay;

	assign bopt         = BUF_W'(({1'b0, buffer_low_q} + {1'b0, buffer_high_q}) >> 1);
	assign bt_minus_taf = {1'b0, in_buf} - {1'b0, segment_dur_q};
	assign wait_c       = ($signed(bt_minus_taf) > $signed({1'b0, bopt}))
		? bt_minus_taf : {1'b0, bopt};
	assign fast_delay   = {1'b0, buffer_high_q} - {1'b0, segment_dur_q};

	// Rate table; read data is registered into stage 1.
	logic [RATE_W-1:0] rate_mem [TABLE_DEPTH];
	logic [RATE_W-1:0] cur_rate_s1, up_rate_s1, est_s1;
	logic [QUAL_W-1:0] cur_s1, up_s1, down_s1;
	logic [DELAY_W-1:0] wait_s1;
	logic lt_min_s1, lt_low_s1, lt_high_s1, gt_high_s1, is_top_s1, rising_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rate_mem[in_level_index[ADDR_W-1:0]] <= in_level_rate;
		end
		if (dec_acc) begin
			cur_rate_s1 <= rate_mem[cur_c[ADDR_W-1:0]];
			up_rate_s1  <= rate_mem[up_c[ADDR_W-1:0]];
			est_s1      <= in_est;
			cur_s1      <= cur_c;
			up_s1       <= up_c;
			down_s1     <= down_c;
			wait_s1     <= wait_c;
			lt_min_s1   <= in_buf < buffer_min_q;
			lt_low_s1   <= in_buf < buffer_low_q;
			lt_high_s1  <= in_buf < buffer_high_q;
			gt_high_s1  <= in_buf > buffer_high_q;
			is_top_s1   <= is_top;
			rising_s1   <= in_rising;
		end
	end

	// Stage 2: rate compares, the scaled ones as exact integer cross-multiplies.
	dec_flags_t flags_c, flags_s2;
	logic [QUAL_W-1:0]  cur_s2, up_s2, down_s2;
	logic [DELAY_W-1:0] wait_s2;

	always_comb begin
		flags_c.fast_ok    = (34'(cur_rate_s1) * 34'd4) <= (34'(est_s1) * 34'd3);
		flags_c.up33_ok    = (39'(up_rate_s1) * 39'd100) <= (39'(est_s1) * 39'd33);
		flags_c.up50_ok    = {up_rate_s1, 1'b0} <= {1'b0, est_s1};
		flags_c.up75_ok    = (34'(up_rate_s1) * 34'd4) <= (34'(est_s1) * 34'd3);
		flags_c.up_hold    = (36'(up_rate_s1) * 36'd10) >= (36'(est_s1) * 36'd9);
		flags_c.cur_ge_est = cur_rate_s1 >= est_s1;
		flags_c.lt_min     = lt_min_s1;
		flags_c.lt_low     = lt_low_s1;
		flags_c.lt_high    = lt_high_s1;
		flags_c.gt_high    = gt_high_s1;
		flags_c.is_top     = is_top_s1;
		flags_c.rising     = rising_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			flags_s2 <= flags_c;
			cur_s2   <= cur_s1;
			up_s2    <= up_s1;
			down_s2  <= down_s1;
			wait_s2  <= wait_s1;
		end
	end

	// Stage 3: decision into the output register.
	logic               fast_start_q;
	logic [QUAL_W-1:0]  next_c, next_q;
	logic [DELAY_W-1:0] delay_c, delay_q;
	logic               fast_end;

	btbs_decide u_decide (
		.fast_start (fast_start_q),
		.flags      (flags_s2),
		.cur        (cur_s2),
		.up         (up_s2),
		.down       (down_s2),
		.wait_us    (wait_s2),
		.fast_delay (fast_delay),
		.next_level (next_c),
		.delay_us   (delay_c),
		.fast_end   (fast_end)
	);

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			next_q  <= next_c;
			delay_q <= delay_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
			fast_start_q <= 1'b1;
		end else begin
			if (en_s1) v_s1 <= dec_acc;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) out_valid_q <= v_s2;
			// Fast start ends for good at the first decision that leaves it.
			if (en_s3 && v_s2 && fast_end) fast_start_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, delay_q, next_q};

endmodule
`default_nettype wire

// File: rtl/btbs_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// btbs_chk: port-level checks of the bitrate selector
// Watches the stream ports for stall behavior, readiness and latency.
// -----------------------------------------------------------------------------
module btbs_chk import btbs_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic [IN_TDATA_W-1:0]  s_tdata,
	input wire logic                   s_tuser,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	logic dec_acc;

	assign dec_acc = s_tvalid && s_tready && (s_tuser == OP_DECIDE)
		&& !s_tdata[IN_FIRST_BIT];

	// A stalled result stays put until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A ready receiver never back-pressures the input side.
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with receiver ready");

	// A decision reaches the output register when the receiver stays ready behind it.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		dec_acc ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("decision result late");

	// The padding above the delay field is always zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:QUAL_W+DELAY_W] == '0)
		else $error("nonzero padding in result");

endmodule

bind buffer_threshold_bitrate_select_top btbs_chk u_btbs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// File: tb/buffer_threshold_bitrate_select_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// buffer_threshold_bitrate_select_checker: decision scoreboard
// Follows the configuration port and both streams, keeps its own rate table,
// thresholds and fast-start flag, computes the next level and delay of every
// decide transaction without the first-segment flag and compares them in order
// with the results. Register reads are checked against the values written.
// -----------------------------------------------------------------------------
module buffer_threshold_bitrate_select_checker import btbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	input  wire logic [APB_DATA_W-1:0] prdata,
	input  wire logic                  pready,
	output int                         errors,
	output int                         waiting
);

	localparam int LEVELS = 16;

	typedef struct packed {
		logic [QUAL_W-1:0]  quality;
		logic [DELAY_W-1:0] delay;
	} decision_t;

	logic [LCNT_W-1:0] level_count;
	logic [BUF_W-1:0]  buffer_min;
	logic [BUF_W-1:0]  buffer_low;
	logic [BUF_W-1:0]  buffer_high;
	logic [BUF_W-1:0]  segment_dur;
	logic [RATE_W-1:0] rates [LEVELS];
	logic              fast_start;
	decision_t         decisions_due [$];

	initial begin
		errors = 0;
		waiting = 0;
	end

	// Next level and delay for one decide transaction; leaving fast start
	// clears the flag for the rest of the run.
	function automatic decision_t choose_level(input logic [QUAL_W-1:0] cur_in,
			input logic [RATE_W-1:0] est_in, input logic [BUF_W-1:0] buf_in,
			input logic rising);
		int unsigned count;
		int unsigned top;
		int unsigned cur;
		int unsigned up;
		int unsigned down;
		int unsigned next;
		logic [63:0] est;
		logic [63:0] cur_rate;
		logic [63:0] up_rate;
		longint      bt;
		longint      bmin;
		longint      blow;
		longint      bhigh;
		longint      taf;
		longint      bopt;
		longint      hold_wait;
		longint      dly;
		logic        hold;
		decision_t   d;
		count = level_count;
		if (count < 1) count = 1;
		if (count > LEVELS) count = LEVELS;
		top = count - 1;
		cur = cur_in;
		if (cur > top) cur = top;
		up = (cur + 1 < count) ? cur + 1 : cur;
		down = (cur >= 1) ? cur - 1 : cur;
		est = {32'd0, est_in};
		cur_rate = {32'd0, rates[cur]};
		up_rate = {32'd0, rates[up]};
		bt = longint'({32'd0, buf_in});
		bmin = longint'({32'd0, buffer_min});
		blow = longint'({32'd0, buffer_low});
		bhigh = longint'({32'd0, buffer_high});
		taf = longint'({32'd0, segment_dur});
		bopt = (blow + bhigh) / 2;
		next = cur;
		dly = 0;
		if (fast_start && cur != top && rising && 64'd4 * cur_rate <= 64'd3 * est) begin
			if (bt < bmin) begin
				if (64'd100 * up_rate <= 64'd33 * est) next = up;
			end else if (bt < blow) begin
				if (64'd2 * up_rate <= est) next = up;
			end else begin
				if (64'd4 * up_rate <= 64'd3 * est) next = up;
				if (bt > bhigh) dly = bhigh - taf;
			end
		end else begin
			fast_start = 1'b0;
			hold = (cur == top) || (64'd10 * up_rate >= 64'd9 * est);
			hold_wait = (bt - taf > bopt) ? bt - taf : bopt;
			if (bt < bmin) begin
				next = 0;
			end else if (bt < blow) begin
				if (cur != 0 && cur_rate >= est) next = down;
			end else if (bt < bhigh) begin
				if (hold) dly = hold_wait;
			end else begin
				if (hold) dly = hold_wait;
				else next = up;
			end
		end
		d.quality = QUAL_W'(next);
		d.delay = dly[DELAY_W-1:0];
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		decision_t               seen;
		decision_t               due;
		logic [REG_IDX_W-1:0]    reg_idx;
		logic [APB_DATA_W-1:0]   reg_now;
		if (!arst_n) begin
			level_count = RST_LEVEL_COUNT;
			buffer_min = RST_BUFFER_MIN;
			buffer_low = RST_BUFFER_LOW;
			buffer_high = RST_BUFFER_HIGH;
			segment_dur = RST_SEGMENT_DUR;
			fast_start = 1'b1;
			decisions_due.delete();
			waiting = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.quality = m_tdata[QUAL_W-1:0];
				seen.delay = m_tdata[QUAL_W +: DELAY_W];
				if (decisions_due.size() == 0) begin
					errors++;
					$display("%0t: result with no decision pending: expected none, got level %0d delay %0d",
						$time, seen.quality, $signed(seen.delay));
				end else begin
					due = decisions_due.pop_front();
					if (seen.quality !== due.quality) begin
						errors++;
						$display("%0t: next_level expected %0d, got %0d",
							$time, due.quality, seen.quality);
					end
					if (seen.delay !== due.delay) begin
						errors++;
						$display("%0t: delay_us expected %0d, got %0d",
							$time, $signed(due.delay), $signed(seen.delay));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser) == OP_WRITE)
					rates[s_tdata[IN_LIDX_LSB +: QUAL_W]] = s_tdata[IN_LRATE_LSB +: RATE_W];
				else if (!s_tdata[IN_FIRST_BIT])
					decisions_due.push_back(choose_level(s_tdata[IN_CUR_LSB +: QUAL_W],
						s_tdata[IN_EST_LSB +: RATE_W], s_tdata[IN_BUF_LSB +: BUF_W],
						s_tdata[IN_RISE_BIT]));
			end
			if (psel && penable && pready) begin
				reg_idx = paddr[APB_ADDR_W-1:2];
				if (pwrite) begin
					case (reg_idx)
						REG_LEVEL_COUNT: level_count = pwdata[LCNT_W-1:0];
						REG_BUFFER_MIN:  buffer_min = pwdata;
						REG_BUFFER_LOW:  buffer_low = pwdata;
						REG_BUFFER_HIGH: buffer_high = pwdata;
						REG_SEGMENT_DUR: segment_dur = pwdata;
						default: ;
					endcase
				end else begin
					case (reg_idx)
						REG_LEVEL_COUNT: reg_now = APB_DATA_W'(level_count);
						REG_BUFFER_MIN:  reg_now = buffer_min;
						REG_BUFFER_LOW:  reg_now = buffer_low;
						REG_BUFFER_HIGH: reg_now = buffer_high;
						REG_SEGMENT_DUR: reg_now = segment_dur;
						default:         reg_now = '0;
					endcase
					if (prdata !== reg_now) begin
						errors++;
						$display("%0t: register %0d read expected %h, got %h",
							$time, reg_idx, reg_now, prdata);
					end
				end
			end
			waiting = decisions_due.size();
		end
	end

endmodule

// File: tb/buffer_threshold_bitrate_select_top_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// buffer_threshold_bitrate_select_top_test: testbench of the bitrate selector
// Fills the rate table, runs a directed set of fast-start and buffer-zone
// decisions, then several register settings with random write and decide
// transactions under random source gaps and sink stalls. The checker beside
// the block predicts and compares every result.
// -----------------------------------------------------------------------------
module buffer_threshold_bitrate_select_top_test;
	import btbs_pkg::*;

	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 205;
	localparam int SETTLE_CYCLES = 8;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;
	int                     chk_errors;
	int                     chk_waiting;

	logic                   sender_calm;
	logic                   receiver_calm;
	logic [RATE_W-1:0]      rate_seen [16];
	logic [BUF_W-1:0]       thr_min;
	logic [BUF_W-1:0]       thr_low;
	logic [BUF_W-1:0]       thr_high;
	logic [BUF_W-1:0]       seg_dur;

	buffer_threshold_bitrate_select_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	buffer_threshold_bitrate_select_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(chk_errors), .waiting(chk_waiting)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [IN_TDATA_W-1:0] pack_item(input logic [QUAL_W-1:0] lidx,
			input logic [RATE_W-1:0] lrate, input logic [QUAL_W-1:0] cur,
			input logic [RATE_W-1:0] est, input logic [BUF_W-1:0] bt,
			input logic rising, input logic first);
		logic [IN_TDATA_W-1:0] d;
		d = '0;
		d[IN_LIDX_LSB +: QUAL_W] = lidx;
		d[IN_LRATE_LSB +: RATE_W] = lrate;
		d[IN_CUR_LSB +: QUAL_W] = cur;
		d[IN_EST_LSB +: RATE_W] = est;
		d[IN_BUF_LSB +: BUF_W] = bt;
		d[IN_RISE_BIT] = rising;
		d[IN_FIRST_BIT] = first;
		return d;
	endfunction

	// Starts and ends on a falling edge; the transaction completes at the
	// rising edge where s_tready is seen high.
	task automatic send_item(input op_t op, input logic [IN_TDATA_W-1:0] data);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_rate(input logic [QUAL_W-1:0] idx, input logic [RATE_W-1:0] rate);
		rate_seen[idx] = rate;
		send_item(OP_WRITE, pack_item(idx, rate, QUAL_W'($urandom_range(0, 15)), $urandom,
			$urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
	endtask

	task automatic decide(input logic [QUAL_W-1:0] cur, input logic [RATE_W-1:0] est,
			input logic [BUF_W-1:0] bt, input logic rising, input logic first);
		send_item(OP_DECIDE, pack_item(QUAL_W'($urandom_range(0, 15)), $urandom, cur, est, bt,
			rising, first));
	endtask

	// Setup and access phase; returns at the completing rising edge with psel still high.
	task automatic reg_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
			input logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
		reg_access(1'b1, idx, value);
		reg_access(1'b0, idx, '0);
	endtask

	task automatic configure(input logic [LCNT_W-1:0] cnt, input logic [BUF_W-1:0] mn,
			input logic [BUF_W-1:0] lo, input logic [BUF_W-1:0] hi, input logic [BUF_W-1:0] seg);
		// The last transaction was already taken; keep it from being sent again.
		s_tvalid <= 1'b0;
		// Writes and first-segment decides leave no trace in the result
		// count, so give the pipeline time to drain them as well.
		wait (chk_waiting == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		thr_min = mn;
		thr_low = lo;
		thr_high = hi;
		seg_dur = seg;
		set_register(REG_LEVEL_COUNT, APB_DATA_W'(cnt));
		set_register(REG_BUFFER_MIN, mn);
		set_register(REG_BUFFER_LOW, lo);
		set_register(REG_BUFFER_HIGH, hi);
		set_register(REG_SEGMENT_DUR, seg);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Estimates are mostly placed on the scaled-rate boundaries of the
	// current or next level, buffer levels often on the thresholds.
	task automatic random_item();
		int unsigned        pick;
		logic [QUAL_W-1:0]  cur;
		logic [QUAL_W-1:0]  up_lvl;
		logic [RATE_W-1:0]  rate;
		logic [63:0]        base;
		logic [63:0]        e;
		logic [RATE_W-1:0]  est;
		logic [BUF_W-1:0]   bt;
		logic [63:0]        mid;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			case ($urandom_range(0, 3))
				0: rate = $urandom;
				1: rate = '0;
				2: rate = '1;
				default: rate = $urandom_range(0, 50_000_000);
			endcase
			write_rate(QUAL_W'($urandom_range(0, 15)), rate);
		end else begin
			cur = QUAL_W'($urandom_range(0, 15));
			up_lvl = (cur == 4'd15) ? cur : cur + 4'd1;
			base = {32'd0, ($urandom_range(0, 1) != 0) ? rate_seen[cur] : rate_seen[up_lvl]};
			case ($urandom_range(0, 8))
				0: e = base * 4 / 3;
				1: e = base * 2;
				2: e = base * 100 / 33;
				3: e = base * 10 / 9;
				4: e = base;
				5: e = 64'd0;
				6: e = 64'hFFFF_FFFF;
				default: e = {32'd0, $urandom};
			endcase
			if (pick % 2 != 0) e = e + $urandom_range(0, 2) - 1;
			est = (e > 64'hFFFF_FFFF) ? '1 : e[31:0];
			mid = ({32'd0, thr_low} + {32'd0, thr_high}) / 2 + {32'd0, seg_dur};
			case ($urandom_range(0, 9))
				0: bt = '0;
				1: bt = '1;
				2: bt = thr_min + $urandom_range(0, 2) - 1;
				3: bt = thr_low + $urandom_range(0, 2) - 1;
				4: bt = thr_high + $urandom_range(0, 2) - 1;
				5: bt = mid[31:0] + $urandom_range(0, 2) - 1;
				default: bt = $urandom;
			endcase
			decide(cur, est, bt, 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
		end
	endtask

	// Sink: a random stall before each result, none while receiver_calm is set.
	initial begin : sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = receiver_calm ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		logic [BUF_W-1:0] o_min;
		logic [BUF_W-1:0] o_low;
		logic [BUF_W-1:0] o_high;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_WRITE;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		thr_min = RST_BUFFER_MIN;
		thr_low = RST_BUFFER_LOW;
		thr_high = RST_BUFFER_HIGH;
		seg_dur = RST_SEGMENT_DUR;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every table entry is written before any decision can read it.
		for (int i = 0; i < 15; i++)
			write_rate(QUAL_W'(i), RATE_W'(i * 1_000_000));
		write_rate(4'd15, '1);

		// Fast start under the reset thresholds, then the plain buffer zones.
		decide(4'd3, 32'd4_000_000, 32'd0, 1'b1, 1'b1);
		decide(4'd0, 32'd4_000_000, 32'd0, 1'b1, 1'b0);
		decide(4'd1, 32'd4_000_000, 32'd15_000_000, 1'b1, 1'b0);
		decide(4'd2, 32'd4_000_000, 32'd50_000_000, 1'b1, 1'b0);
		decide(4'd3, '1, 32'd30_000_000, 1'b0, 1'b0);
		decide(4'd7, 32'd1_000_000, 32'd5_000_000, 1'b1, 1'b0);
		decide(4'd5, 32'd5_000_000, 32'd15_000_000, 1'b0, 1'b0);
		decide(4'd14, '1, '1, 1'b1, 1'b0);
		decide(4'd3, 32'd100_000_000, 32'd45_000_000, 1'b0, 1'b0);
		decide(4'd15, 32'd0, 32'd0, 1'b1, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			o_min = $urandom_range(0, 1_000_000_000);
			o_low = o_min + $urandom_range(0, 1_000_000_000);
			o_high = o_low + $urandom_range(0, 1_000_000_000);
			case (phase)
				0: configure(5'd16, 32'd10_000_000, 32'd20_000_000, 32'd40_000_000, 32'd50_000_000);
				1: configure(5'd0, '0, '0, '0, '0);
				2: configure(5'd31, '1, '1, '1, '1);
				3: configure(5'd1, o_min, o_low, o_high, $urandom_range(0, 100_000_000));
				4: configure(5'd17, $urandom, $urandom, $urandom, $urandom);
				5: configure(LCNT_W'($urandom_range(2, 15)), o_min, o_low, o_high,
					$urandom_range(0, 100_000_000));
				6: configure(5'd8, RST_BUFFER_MIN, RST_BUFFER_LOW, RST_BUFFER_HIGH, '1);
				7: configure(LCNT_W'($urandom_range(0, 31)), $urandom, $urandom, $urandom, $urandom);
				default: configure(5'd5, o_min % 30_000, o_low % 60_000, o_high % 100_000,
					$urandom_range(0, 100_000));
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 40 == 0) begin
					sender_calm = ($urandom_range(0, 3) == 0);
					receiver_calm = ($urandom_range(0, 3) == 0);
				end
				random_item();
			end
		end
		s_tvalid <= 1'b0;

		for (int c = 0; c < 5000 && chk_waiting != 0; c++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (chk_waiting != 0)
			$display("%0t: %0d decisions never produced a result", $time, chk_waiting);
		if (chk_errors == 0 && chk_waiting == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: buffer_threshold_bitrate_select_top.f
rtl/btbs_pkg.sv
rtl/btbs_decide.sv
rtl/buffer_threshold_bitrate_select_top.sv
rtl/btbs_chk.sv
tb/buffer_threshold_bitrate_select_checker.sv
tb/buffer_threshold_bitrate_select_top_test.sv
